FILE: rtl/rpgf_pkg.sv
`timescale 1ns / 1ps

package rpgf_pkg;

	// exp table sizing
	localparam int EXP_ENTRIES_DEFAULT = 256;
	localparam int EXP_ENTRIES_MAX     = 4096;
	localparam int EXP_W               = 17;
	localparam int EXP_ONE             = 65536;
	localparam int TAB_BITS            = EXP_W * (EXP_ENTRIES_MAX + 1);

	// u in Q.16 below 16, and the interpolation fraction
	localparam int U_W = 20;
	localparam int F_W = 20;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// mode bits
	localparam int MODE_MAX_BIT  = 0;
	localparam int MODE_PERT_BIT = 1;

	// output range
	localparam int OUT_W   = 19;
	localparam int OUT_MIN = -65536;
	localparam int OUT_MAX = 131072;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X      = 3'd0,
		REG_CENTER_Y      = 3'd1,
		REG_CENTER_Z      = 3'd2,
		REG_STRIKE_LENGTH = 3'd3,
		REG_DIP_LENGTH    = 3'd4,
		REG_INV_SIGMA_SQ  = 3'd5,
		REG_PEAK_VALUE    = 3'd6,
		REG_MODE          = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [30:0]        strike_length;
		logic [30:0]        dip_length;
		logic [31:0]        inv_sigma_sq;
		logic [16:0]        peak_value;
		logic [1:0]         mode;
	} cfg_t;

	// per-point values that ride along the pipeline
	typedef struct packed {
		logic [16:0] bg;
		logic [17:0] pert;
	} side_t;

	// squared distance and far-point flag
	typedef struct packed {
		logic        far;
		logic [63:0] r2;
	} dist_t;

	// floor division by a small loop count
	function automatic logic [63:0] div_small(input logic [63:0] x, input int k);
		logic [63:0] q;
		case (k)
			1:  q = x;
			2:  q = x / 64'd2;
			3:  q = x / 64'd3;
			4:  q = x / 64'd4;
			5:  q = x / 64'd5;
			6:  q = x / 64'd6;
			7:  q = x / 64'd7;
			8:  q = x / 64'd8;
			9:  q = x / 64'd9;
			10: q = x / 64'd10;
			11: q = x / 64'd11;
			12: q = x / 64'd12;
			13: q = x / 64'd13;
			14: q = x / 64'd14;
			15: q = x / 64'd15;
			16: q = x / 64'd16;
			17: q = x / 64'd17;
			18: q = x / 64'd18;
			19: q = x / 64'd19;
			20: q = x / 64'd20;
			default: q = x;
		endcase
		return q;
	endfunction

	// exp(-u) samples at u = 16*i/n, packed EXP_W bits per entry
	function automatic logic [TAB_BITS-1:0] exp_table(input logic [63:0] step, input int n);
		logic [63:0]         term;
		logic [63:0]         sum;
		logic [63:0]         p;
		logic [63:0]         ent;
		logic [TAB_BITS-1:0] tab;
		tab  = '0;
		term = 64'd1 << 31;
		sum  = 64'd1 << 31;
		p    = 64'd1 << 31;
		// q = exp(-16/n) in Q.31 by taylor series
		for (int k = 1; k <= 20; k++) begin
			term = div_small((term * step) >> 31, k);
			if ((k & 1) == 1) begin
				sum = (sum > term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		tab[EXP_W-1:0] = EXP_W'(EXP_ONE);
		// successive powers of q, rounded to Q.16
		for (int i = 1; i <= EXP_ENTRIES_MAX; i++) begin
			if (i <= n) begin
				p   = (p * sum + (64'd1 << 30)) >> 31;
				ent = (p + (64'd1 << 14)) >> 15;
				tab[i*EXP_W +: EXP_W] = ent[EXP_W-1:0];
			end
		end
		return tab;
	endfunction

endpackage

FILE: rtl/rpgf_point_if.sv
`timescale 1ns / 1ps

interface rpgf_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [16:0]        background_alpha;
	logic signed [17:0] perturbation;

	modport source(
		output valid, pos_x, pos_y, pos_z, background_alpha, perturbation,
		input  ready
	);
	modport sink(
		input  valid, pos_x, pos_y, pos_z, background_alpha, perturbation,
		output ready
	);
endinterface

FILE: rtl/rpgf_result_if.sv
`timescale 1ns / 1ps

interface rpgf_result_if;
	logic               valid;
	logic               ready;
	logic signed [18:0] breakage;

	modport source(
		output valid, breakage,
		input  ready
	);
	modport sink(
		input  valid, breakage,
		output ready
	);
endinterface

FILE: rtl/rpgf_geom.sv
`timescale 1ns / 1ps

module rpgf_geom (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  rpgf_pkg::cfg_t      cfg,
	input  logic                pt_valid,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  rpgf_pkg::side_t     pt_side,
	output logic                dist_valid,
	output rpgf_pkg::dist_t     sqd,
	output rpgf_pkg::side_t     dist_side
);

	// stage 1: doubled coordinates and rectangle bounds
	logic signed [34:0] px_w, pz_w, cx_w, cz_w, sl_w, dl_w;
	logic signed [32:0] dy_w;
	logic               v_s1;
	logic signed [34:0] px_s1, lo_x_s1, hi_x_s1, pz_s1, lo_z_s1, hi_z_s1;
	logic signed [32:0] dy_s1;
	rpgf_pkg::side_t    side_s1;

	always_comb begin
		px_w = {{2{pos_x[31]}}, pos_x, 1'b0};
		pz_w = {{2{pos_z[31]}}, pos_z, 1'b0};
		cx_w = {{2{cfg.center_x[31]}}, cfg.center_x, 1'b0};
		cz_w = {{2{cfg.center_z[31]}}, cfg.center_z, 1'b0};
		sl_w = {4'b0, cfg.strike_length};
		dl_w = {4'b0, cfg.dip_length};
		dy_w = {pos_y[31], pos_y} - {cfg.center_y[31], cfg.center_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= px_w;
			lo_x_s1 <= cx_w - sl_w;
			hi_x_s1 <= cx_w + sl_w;
			pz_s1   <= pz_w;
			lo_z_s1 <= cz_w - dl_w;
			hi_z_s1 <= cz_w + dl_w;
			dy_s1   <= dy_w;
			side_s1 <= pt_side;
		end
	end

	// stage 2: distance outside the rectangle per axis, far test
	logic signed [34:0] ax_d, az_d;
	logic [32:0]        dy_abs;
	logic               far_w;
	logic               v_s2, far_s2;
	logic [30:0]        ax_s2, ay_s2, az_s2;
	rpgf_pkg::side_t    side_s2;

	always_comb begin
		if (px_s1 < lo_x_s1) begin
			ax_d = lo_x_s1 - px_s1;
		end else if (px_s1 > hi_x_s1) begin
			ax_d = px_s1 - hi_x_s1;
		end else begin
			ax_d = '0;
		end
		if (pz_s1 < lo_z_s1) begin
			az_d = lo_z_s1 - pz_s1;
		end else if (pz_s1 > hi_z_s1) begin
			az_d = pz_s1 - hi_z_s1;
		end else begin
			az_d = '0;
		end
		dy_abs = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
		far_w  = (|ax_d[34:31]) || (|az_d[34:31]) || (|dy_abs[32:30]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2   <= ax_d[30:0];
			ay_s2   <= {dy_abs[29:0], 1'b0};
			az_s2   <= az_d[30:0];
			far_s2  <= far_w;
			side_s2 <= side_s1;
		end
	end

	// stage 3: squares
	logic            v_s3, far_s3;
	logic [61:0]     sq_x_s3, sq_y_s3, sq_z_s3;
	rpgf_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s3 <= 62'(ax_s2) * 62'(ax_s2);
			sq_y_s3 <= 62'(ay_s2) * 62'(ay_s2);
			sq_z_s3 <= 62'(az_s2) * 62'(az_s2);
			far_s3  <= far_s2;
			side_s3 <= side_s2;
		end
	end

	// stage 4: sum of squares
	logic            v_s4;
	rpgf_pkg::dist_t dist_s4;
	rpgf_pkg::side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s4.r2  <= 64'(sq_x_s3) + 64'(sq_y_s3) + 64'(sq_z_s3);
			dist_s4.far <= far_s3;
			side_s4     <= side_s3;
		end
	end

	assign dist_valid = v_s4;
	assign sqd        = dist_s4;
	assign dist_side  = side_s4;

endmodule

FILE: rtl/rpgf_exp.sv
`timescale 1ns / 1ps

module rpgf_exp #(
	parameter int EXP_TABLE_ENTRIES = rpgf_pkg::EXP_ENTRIES_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [31:0]                   inv_sigma_sq,
	input  logic                          dist_valid,
	input  rpgf_pkg::dist_t               sqd,
	input  rpgf_pkg::side_t               dist_side,
	output logic                          fall_valid,
	output logic [rpgf_pkg::EXP_W-1:0]    fall,
	output rpgf_pkg::side_t               fall_side
);

	localparam int EW    = rpgf_pkg::EXP_W;
	localparam int UW    = rpgf_pkg::U_W;
	localparam int FW    = rpgf_pkg::F_W;
	localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES + 1);
	localparam int P_W   = UW + IDX_W;
	localparam logic [63:0] TaylorStep = (64'd1 << 35) / EXP_TABLE_ENTRIES;
	localparam logic [rpgf_pkg::TAB_BITS-1:0] ExpTab =
		rpgf_pkg::exp_table(TaylorStep, EXP_TABLE_ENTRIES);

	// constant exp table
	logic [EW-1:0] tab [0:EXP_TABLE_ENTRIES];

	for (genvar gi = 0; gi <= EXP_TABLE_ENTRIES; gi++) begin : g_tab
		assign tab[gi] = ExpTab[gi*EW +: EW];
	end

	// stage 5: scale r2 by 1/sigma^2, high and low halves
	logic            v_s5, far_s5, zero_s5;
	logic [63:0]     a_s5, b_s5;
	rpgf_pkg::side_t side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dist_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5    <= 64'(sqd.r2[63:32]) * 64'(inv_sigma_sq);
			b_s5    <= 64'(sqd.r2[31:0]) * 64'(inv_sigma_sq);
			far_s5  <= sqd.far;
			zero_s5 <= (inv_sigma_sq == '0);
			side_s5 <= dist_side;
		end
	end

	// stage 6: u in Q.16, flag u of 16 or more
	logic [38:0]     u_sum;
	logic            big_w;
	logic            v_s6, big_s6;
	logic [UW-1:0]   u_s6;
	rpgf_pkg::side_t side_s6;

	always_comb begin
		u_sum = 39'({a_s5[13:0], 6'b0}) + 39'(b_s5[63:26]);
		big_w = !zero_s5 && (far_s5 || (|a_s5[63:14]) || (|u_sum[38:UW]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s6    <= zero_s5 ? '0 : u_sum[UW-1:0];
			big_s6  <= big_w;
			side_s6 <= side_s5;
		end
	end

	// stage 7: table position and fraction
	logic [P_W-1:0]   pos_w;
	logic             v_s7, big_s7;
	logic [IDX_W-1:0] idx_s7;
	logic [FW-1:0]    f_s7;
	rpgf_pkg::side_t  side_s7;

	assign pos_w = P_W'(u_s6) * P_W'(EXP_TABLE_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s7  <= pos_w[P_W-1:FW];
			f_s7    <= pos_w[FW-1:0];
			big_s7  <= big_s6;
			side_s7 <= side_s6;
		end
	end

	// stage 8: table lookup of both neighbors
	logic            v_s8, big_s8;
	logic [EW-1:0]   e0_s8, e1_s8;
	logic [FW-1:0]   f_s8;
	rpgf_pkg::side_t side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e0_s8   <= tab[idx_s7];
			e1_s8   <= tab[IDX_W'(idx_s7 + 1'b1)];
			f_s8    <= f_s7;
			big_s8  <= big_s7;
			side_s8 <= side_s7;
		end
	end

	// stage 9: slope times fraction
	logic [EW-1:0]      diff_w;
	logic               v_s9, big_s9;
	logic [EW-1:0]      e0_s9;
	logic [EW+FW-1:0]   prod_s9;
	rpgf_pkg::side_t    side_s9;

	assign diff_w = (e0_s8 > e1_s8) ? e0_s8 - e1_s8 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s9 <= (EW+FW)'(diff_w) * (EW+FW)'(f_s8);
			e0_s9   <= e0_s8;
			big_s9  <= big_s8;
			side_s9 <= side_s8;
		end
	end

	// stage 10: interpolated value, zero beyond the table
	logic [EW+FW-1:0] corr_w;
	logic             v_s10;
	logic [EW-1:0]    e_s10;
	rpgf_pkg::side_t  side_s10;

	assign corr_w = prod_s9 + (EW+FW)'(1 << (FW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s10    <= big_s9 ? '0 : e0_s9 - corr_w[EW+FW-1:FW];
			side_s10 <= side_s9;
		end
	end

	assign fall_valid = v_s10;
	assign fall       = e_s10;
	assign fall_side  = side_s10;

endmodule

FILE: rtl/rect_plane_gaussian_falloff.sv
`timescale 1ns / 1ps
// an accepted point word passes through stages 1 to 12 in order; its result leaves from stage 12
// throughput: one word per cycle without output stalls; a single 12-stage chain with one enable
// a stall at the output freezes every stage, so the input is held off and nothing is lost
// reset (arst_n low) clears all stage valid bits and all configuration registers to zero

module rect_plane_gaussian_falloff #(
	parameter int EXP_TABLE_ENTRIES = rpgf_pkg::EXP_ENTRIES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rpgf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rpgf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	rpgf_point_if.sink                        point,
	rpgf_result_if.source                     result
);

	// configuration registers
	rpgf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (rpgf_pkg::cfg_reg_t'(cfg_index))
				rpgf_pkg::REG_CENTER_X:      cfg_q.center_x      <= cfg_wdata;
				rpgf_pkg::REG_CENTER_Y:      cfg_q.center_y      <= cfg_wdata;
				rpgf_pkg::REG_CENTER_Z:      cfg_q.center_z      <= cfg_wdata;
				rpgf_pkg::REG_STRIKE_LENGTH: cfg_q.strike_length <= cfg_wdata[30:0];
				rpgf_pkg::REG_DIP_LENGTH:    cfg_q.dip_length    <= cfg_wdata[30:0];
				rpgf_pkg::REG_INV_SIGMA_SQ:  cfg_q.inv_sigma_sq  <= cfg_wdata;
				rpgf_pkg::REG_PEAK_VALUE:    cfg_q.peak_value    <= cfg_wdata[16:0];
				rpgf_pkg::REG_MODE:          cfg_q.mode          <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// pipeline advance: output register empty or being taken
	logic v_s12;
	logic en;

	assign en          = !v_s12 || result.ready;
	assign point.ready = en;

	rpgf_pkg::side_t pt_side;

	assign pt_side.bg   = point.background_alpha;
	assign pt_side.pert = point.perturbation;

	// geometry and squared distance
	logic            dist_valid;
	rpgf_pkg::dist_t sqd;
	rpgf_pkg::side_t dist_side;

	rpgf_geom u_geom (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.cfg        (cfg_q),
		.pt_valid   (point.valid),
		.pos_x      (point.pos_x),
		.pos_y      (point.pos_y),
		.pos_z      (point.pos_z),
		.pt_side    (pt_side),
		.dist_valid (dist_valid),
		.sqd        (sqd),
		.dist_side  (dist_side)
	);

	// gaussian falloff from the exp table
	logic                       fall_valid;
	logic [rpgf_pkg::EXP_W-1:0] fall;
	rpgf_pkg::side_t            fall_side;

	rpgf_exp #(
		.EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
	) u_exp (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.inv_sigma_sq (cfg_q.inv_sigma_sq),
		.dist_valid   (dist_valid),
		.sqd          (sqd),
		.dist_side    (dist_side),
		.fall_valid   (fall_valid),
		.fall         (fall),
		.fall_side    (fall_side)
	);

	// stage 11: scale by peak with rounding
	logic [33:0]     scaled_w;
	logic            v_s11;
	logic [17:0]     alpha_s11;
	rpgf_pkg::side_t side_s11;

	assign scaled_w = 34'(cfg_q.peak_value) * 34'(fall) + 34'(1 << 15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= fall_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s11 <= scaled_w[33:16];
			side_s11  <= fall_side;
		end
	end

	// stage 12: background max, perturbation, saturation
	logic [17:0]                    amax_w;
	logic signed [19:0]             total_w;
	logic signed [19:0]             pert_w;
	logic [rpgf_pkg::OUT_W-1:0]     sat_w;
	logic [rpgf_pkg::OUT_W-1:0]     breakage_s12;

	always_comb begin
		if (cfg_q.mode[rpgf_pkg::MODE_MAX_BIT] && (18'(side_s11.bg) > alpha_s11)) begin
			amax_w = 18'(side_s11.bg);
		end else begin
			amax_w = alpha_s11;
		end
		pert_w  = cfg_q.mode[rpgf_pkg::MODE_PERT_BIT] ?
			{{2{side_s11.pert[17]}}, side_s11.pert} : '0;
		total_w = $signed({2'b0, amax_w}) + pert_w;
		if (total_w < 20'(rpgf_pkg::OUT_MIN)) begin
			sat_w = rpgf_pkg::OUT_W'(rpgf_pkg::OUT_MIN);
		end else if (total_w > 20'(rpgf_pkg::OUT_MAX)) begin
			sat_w = rpgf_pkg::OUT_W'(rpgf_pkg::OUT_MAX);
		end else begin
			sat_w = total_w[rpgf_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			breakage_s12 <= sat_w;
		end
	end

	assign result.valid    = v_s12;
	assign result.breakage = breakage_s12;

	// checks
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ($signed(result.breakage) >= rpgf_pkg::OUT_MIN) &&
			($signed(result.breakage) <= rpgf_pkg::OUT_MAX))
		else $error("breakage outside saturation range");

	a_fall_max: assert property (@(posedge clk) disable iff (!arst_n)
		fall_valid |-> (fall <= rpgf_pkg::EXP_W'(rpgf_pkg::EXP_ONE)))
		else $error("interpolated falloff above one");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s11) && $stable(alpha_s11) && $stable(side_s11))
		else $error("scale stage moved during a stall");

endmodule

FILE: tb/rpgf_breakage_check.sv
`timescale 1ns / 1ps

module rpgf_breakage_check #(
	parameter int ENTRIES = rpgf_pkg::EXP_ENTRIES_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rpgf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpgf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rpgf_point_if                           point,
	rpgf_result_if                          result,
	output int                              mismatches,
	output int                              outstanding,
	output int                              checked
);

	// exp(-u) samples at u = 16*i/ENTRIES, Q1.16
	logic [rpgf_pkg::EXP_W-1:0]        exp_lut [0:rpgf_pkg::EXP_ENTRIES_MAX];
	rpgf_pkg::cfg_t                    regs;
	logic signed [rpgf_pkg::OUT_W-1:0] breakage_q [$];

	initial begin
		logic [63:0] step;
		logic [63:0] term;
		logic [63:0] ratio;
		logic [63:0] pw;
		logic [63:0] ent;
		step  = (64'd1 << 35) / 64'(ENTRIES);
		term  = 64'd1 << 31;
		ratio = 64'd1 << 31;
		// exp(-16/ENTRIES) in Q.31, alternating series
		for (int k = 1; k <= 20; k++) begin
			term = ((term * step) >> 31) / 64'(k);
			if (k % 2 == 1)
				ratio = (ratio > term) ? ratio - term : 64'd0;
			else
				ratio = ratio + term;
		end
		exp_lut[0] = rpgf_pkg::EXP_W'(rpgf_pkg::EXP_ONE);
		pw = 64'd1 << 31;
		for (int i = 1; i <= ENTRIES; i++) begin
			pw = (pw * ratio + (64'd1 << 30)) >> 31;
			ent = (pw + (64'd1 << 14)) >> 15;
			exp_lut[i] = ent[rpgf_pkg::EXP_W-1:0];
		end
	end

	function automatic logic [63:0] magnitude(input longint d);
		return (d < 0) ? 64'(-d) : 64'(d);
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// damage at one point under the current register settings
	function automatic logic signed [rpgf_pkg::OUT_W-1:0] falloff_breakage(
		input logic signed [31:0] x_i,
		input logic signed [31:0] y_i,
		input logic signed [31:0] z_i,
		input logic [16:0]        bg,
		input logic signed [17:0] pert
	);
		longint      px, py, pz, cx, cy, cz, sl, dl, alpha;
		logic [63:0] ax, ay, az, r2, hi_part, lo_part, u16, pos, idx, frac;
		logic [63:0] e0, e1, diff, ex;
		logic        far;
		// geometry in doubled units so half extents stay exact
		px = longint'(x_i) * 2;
		py = longint'(y_i);
		pz = longint'(z_i) * 2;
		cx = longint'($signed(regs.center_x)) * 2;
		cy = longint'($signed(regs.center_y));
		cz = longint'($signed(regs.center_z)) * 2;
		sl = longint'(regs.strike_length);
		dl = longint'(regs.dip_length);
		ax = magnitude(px - clip(px, cx - sl, cx + sl));
		ay = magnitude((py - cy) * 2);
		az = magnitude(pz - clip(pz, cz - dl, cz + dl));
		far = (ax >= (64'd1 << 31)) || (ay >= (64'd1 << 31)) || (az >= (64'd1 << 31));
		// u in Q.16
		if (regs.inv_sigma_sq == '0) begin
			u16 = 64'd0;
		end else if (far) begin
			u16 = 64'd1 << 20;
		end else begin
			r2      = ax * ax + ay * ay + az * az;
			hi_part = (r2 >> 32) * 64'(regs.inv_sigma_sq);
			lo_part = (r2 & 64'hFFFF_FFFF) * 64'(regs.inv_sigma_sq);
			if (hi_part >= (64'd1 << 14))
				u16 = 64'd1 << 20;
			else
				u16 = (hi_part << 6) + (lo_part >> 26);
		end
		// interpolated exp(-u), zero from u = 16 on
		if (u16 >= (64'd1 << 20)) begin
			ex = 64'd0;
		end else begin
			pos  = u16 * 64'(ENTRIES);
			idx  = pos >> 20;
			frac = pos & 64'hF_FFFF;
			e0   = 64'(exp_lut[idx]);
			e1   = 64'(exp_lut[idx + 1]);
			diff = (e0 > e1) ? e0 - e1 : 64'd0;
			ex   = e0 - ((diff * frac + (64'd1 << 19)) >> 20);
		end
		alpha = longint'((64'(regs.peak_value) * ex + (64'd1 << 15)) >> 16);
		if (regs.mode[rpgf_pkg::MODE_MAX_BIT] && longint'(bg) > alpha)
			alpha = longint'(bg);
		if (regs.mode[rpgf_pkg::MODE_PERT_BIT])
			alpha = alpha + longint'(pert);
		alpha = clip(alpha, rpgf_pkg::OUT_MIN, rpgf_pkg::OUT_MAX);
		return alpha[rpgf_pkg::OUT_W-1:0];
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// watch config writes, point words and result words
	always @(posedge clk or negedge arst_n) begin
		logic signed [rpgf_pkg::OUT_W-1:0] want;
		if (!arst_n) begin
			regs = '0;
			breakage_q.delete();
			mismatches = 0;
			outstanding = 0;
			checked = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (breakage_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected result word, breakage %0d",
						result.breakage));
				end else begin
					want = breakage_q.pop_front();
					if (result.breakage !== want)
						flag_mismatch($sformatf("breakage %0d, expected %0d",
							result.breakage, want));
					checked++;
				end
			end
			if (cfg_we) begin
				case (rpgf_pkg::cfg_reg_t'(cfg_index))
					rpgf_pkg::REG_CENTER_X:      regs.center_x      = cfg_wdata;
					rpgf_pkg::REG_CENTER_Y:      regs.center_y      = cfg_wdata;
					rpgf_pkg::REG_CENTER_Z:      regs.center_z      = cfg_wdata;
					rpgf_pkg::REG_STRIKE_LENGTH: regs.strike_length = cfg_wdata[30:0];
					rpgf_pkg::REG_DIP_LENGTH:    regs.dip_length    = cfg_wdata[30:0];
					rpgf_pkg::REG_INV_SIGMA_SQ:  regs.inv_sigma_sq  = cfg_wdata;
					rpgf_pkg::REG_PEAK_VALUE:    regs.peak_value    = cfg_wdata[16:0];
					rpgf_pkg::REG_MODE:          regs.mode          = cfg_wdata[1:0];
					default: ;
				endcase
			end
			if (point.valid && point.ready)
				breakage_q.push_back(falloff_breakage(point.pos_x, point.pos_y, point.pos_z,
					point.background_alpha, point.perturbation));
			outstanding = breakage_q.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int NUM_PHASES   = 8;
	localparam int PHASE_POINTS = 220;
	localparam int LIMIT_CYCLES = 400000;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [rpgf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rpgf_pkg::CFG_DATA_W-1:0] cfg_wdata;
	int                              mismatches;
	int                              outstanding;
	int                              checked;
	int                              send_idle_pct;
	int                              recv_stall_pct;
	int                              cycles = 0;
	int                              sent = 0;

	rpgf_point_if  point ();
	rpgf_result_if result ();

	always #6 clk = ~clk;

	rect_plane_gaussian_falloff DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.point     (point),
		.result    (result)
	);

	rpgf_breakage_check u_breakage_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.point       (point),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// receiver back-pressure
	always @(negedge clk)
		result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("rect_plane_gaussian_falloff verification failed");
			$finish;
		end
	end

	task automatic write_reg(input rpgf_pkg::cfg_reg_t idx,
		input logic [rpgf_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	// program all registers once the pipeline has drained
	task automatic load_config(input rpgf_pkg::cfg_t c);
		point.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		write_reg(rpgf_pkg::REG_CENTER_X, c.center_x);
		write_reg(rpgf_pkg::REG_CENTER_Y, c.center_y);
		write_reg(rpgf_pkg::REG_CENTER_Z, c.center_z);
		write_reg(rpgf_pkg::REG_STRIKE_LENGTH, {1'b0, c.strike_length});
		write_reg(rpgf_pkg::REG_DIP_LENGTH, {1'b0, c.dip_length});
		write_reg(rpgf_pkg::REG_INV_SIGMA_SQ, c.inv_sigma_sq);
		write_reg(rpgf_pkg::REG_PEAK_VALUE, {15'd0, c.peak_value});
		write_reg(rpgf_pkg::REG_MODE, {30'd0, c.mode});
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// offer one point word, with optional idle cycles ahead of it
	task automatic send_point(
		input logic [31:0] x,
		input logic [31:0] y,
		input logic [31:0] z,
		input logic [16:0] bg,
		input logic [17:0] pert
	);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			point.valid <= 1'b0;
			@(negedge clk);
		end
		point.valid            <= 1'b1;
		point.pos_x            <= x;
		point.pos_y            <= y;
		point.pos_z            <= z;
		point.background_alpha <= bg;
		point.perturbation     <= pert;
		@(posedge clk);
		while (!point.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// magnitude spread over all scales, either sign
	function automatic longint spread_offset();
		longint mag;
		mag = longint'($urandom) & ((longint'(1) << $urandom_range(0, 30)) - 1);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// coordinate near the center, near the rectangle edge, or anywhere
	function automatic logic [31:0] pick_coord(input logic signed [31:0] c, input longint half);
		longint v;
		case ($urandom_range(0, 7))
			0: return $urandom;
			1, 2, 3: v = longint'(c) + spread_offset();
			default: v = longint'(c) + ($urandom_range(0, 1) ? -half : half) + spread_offset();
		endcase
		return v[31:0];
	endfunction

	function automatic rpgf_pkg::cfg_t phase_config(input int p);
		rpgf_pkg::cfg_t c;
		c = '0;
		case (p)
			0: begin
				// 20 x 10 units, sigma of 4 units, peak above one
				c.strike_length = 31'd5120;
				c.dip_length    = 31'd2560;
				c.inv_sigma_sq  = 32'd1048576;
				c.peak_value    = 17'h1FFFF;
				c.mode          = 2'd3;
			end
			1: begin
				c.center_x      = 32'h7FFF_FFFF;
				c.center_y      = 32'h7FFF_FFFF;
				c.center_z      = 32'h7FFF_FFFF;
				c.strike_length = 31'h7FFF_FFFF;
				c.dip_length    = 31'h7FFF_FFFF;
				c.inv_sigma_sq  = 32'hFFFF_FFFF;
				c.peak_value    = 17'd65536;
				c.mode          = 2'd3;
			end
			2: begin
				// zero decay: flat exp of one everywhere
				c.center_x   = 32'h8000_0000;
				c.center_y   = 32'h8000_0000;
				c.center_z   = 32'h8000_0000;
				c.peak_value = 17'h1FFFF;
				c.mode       = 2'd1;
			end
			3: begin
				c.inv_sigma_sq = 32'd1;
				c.peak_value   = 17'd65536;
				c.mode         = 2'd2;
			end
			default: begin
				c.center_x      = 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
				c.center_y      = 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
				c.center_z      = 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
				c.strike_length = 31'($urandom_range(0, 32'h2_0000));
				c.dip_length    = 31'($urandom_range(0, 32'h2_0000));
				c.inv_sigma_sq  = (32'd1 << $urandom_range(8, 26)) | 32'($urandom_range(0, 255));
				c.peak_value    = 17'($urandom_range(0, 65536));
				c.mode          = 2'(p - 4);
			end
		endcase
		return c;
	endfunction

	initial begin
		rpgf_pkg::cfg_t   c;
		logic [16:0]      bg;
		logic [17:0]      pert;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = '0;
		cfg_wdata              = '0;
		point.valid            = 1'b0;
		point.pos_x            = '0;
		point.pos_y            = '0;
		point.pos_z            = '0;
		point.background_alpha = '0;
		point.perturbation     = '0;
		send_idle_pct          = 0;
		recv_stall_pct         = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < NUM_PHASES; p++) begin
			c = phase_config(p);
			load_config(c);
			// idling pattern for this phase
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase

			if (p == 0) begin
				// inside the rectangle with peak above one, then perturbation extremes
				send_point(32'd0, 32'd0, 32'd0, 17'd0, 18'd0);
				send_point(32'd0, 32'd0, 32'd0, 17'd0, 18'h1FFFF);
				send_point(32'd0, 32'd0, 32'd0, 17'd0, 18'h20000);
				// far point driven to the low saturation
				send_point(32'h7FFF_FFFF, 32'd0, 32'd0, 17'd0, 18'h20000);
				send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'd0, 18'd0);
				send_point(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd0, 18'd0);
				// u exactly 16 and just under it
				send_point(32'd6656, 32'd0, 32'd0, 17'd0, 18'd0);
				send_point(32'd6655, 32'd0, 32'd0, 17'd0, 18'd0);
				send_point(32'd3072, 32'd0, 32'd0, 17'd0, 18'd0);
				// background above one, and background against the perturbation
				send_point(32'h7FFF_FFFF, 32'd0, 32'd0, 17'h1FFFF, 18'd0);
				send_point(32'h8000_0000, 32'd0, 32'd0, 17'd65536, 18'h30000);
				send_point(32'd0, 32'd0, 32'd0, 17'd0, 18'h10000);
				// on the rectangle edge, above the plane, and off a corner
				send_point(32'd2560, 32'd0, 32'd1280, 17'd0, 18'd0);
				send_point(32'd0, 32'd1024, 32'd0, 17'd12345, 18'd0);
				send_point(32'd3584, 32'd512, 32'd1792, 17'd0, 18'h3FFFF);
			end

			for (int i = 0; i < PHASE_POINTS; i++) begin
				bg = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
				if ($urandom_range(0, 7) == 0)
					pert = 18'($urandom);
				else
					pert = 18'($urandom_range(0, 131072) - 65536);
				send_point(pick_coord(c.center_x, longint'(c.strike_length) / 2),
					pick_coord(c.center_y, 0),
					pick_coord(c.center_z, longint'(c.dip_length) / 2),
					bg, pert);
			end
		end
		point.valid <= 1'b0;

		// drain, then let the pipeline run dry
		while (outstanding != 0)
			@(negedge clk);
		repeat (24) @(negedge clk);

		$display("%0d points driven through %0d register settings, %0d results compared",
			sent, NUM_PHASES, checked);
		$display("idling covered none, sender gaps, receiver stalls and both together");
		if (mismatches == 0)
			$display("rect_plane_gaussian_falloff verification clean");
		else
			$display("rect_plane_gaussian_falloff verification failed");
		$finish;
	end

endmodule
